// ===== sv/rvaa_pkg.sv =====
// ----------------------------------------------------------------------------
// Axis-angle rotation package
// Shared types, widths and the CORDIC arctangent table for the rotation core.
// ----------------------------------------------------------------------------
package rvaa_pkg;

  // Field widths of the streaming items.
  localparam int COORD_W = 32;
  localparam int ANGLE_W = 16;

  // Internal number formats.
  localparam int TURN_W       = 32;  // angle as a 32-bit fraction of a turn
  localparam int UNIT_FRAC    = 30;  // fraction bits of unit axis, sin, cos
  localparam int MAG_W        = 30;  // prescaled axis magnitude width
  localparam int CX_W         = 34;  // CORDIC datapath width
  localparam int ATAN_ENTRIES = 24;

  // Queue depths between the channel ports and the datapath.
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 2;

  // Start value of the CORDIC x register, the inverse of the CORDIC gain.
  localparam logic [CX_W-1:0] CORDIC_GAIN = CX_W'(652032874);

  // Quadrant that the angle falls into after centering.
  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_e;

  // One input item.
  typedef struct packed {
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic [COORD_W-1:0] point_z;
    logic [COORD_W-1:0] axis_x;
    logic [COORD_W-1:0] axis_y;
    logic [COORD_W-1:0] axis_z;
    logic [ANGLE_W-1:0] turn_fraction;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [COORD_W-1:0] rotated_x;
    logic [COORD_W-1:0] rotated_y;
    logic [COORD_W-1:0] rotated_z;
    logic               zero_axis;
    logic               saturated;
  } out_item_t;

  // Classified item handed from the front end to the datapath.
  typedef struct packed {
    logic [2:0][COORD_W-1:0] point;
    logic [2:0]              neg;
    logic [2:0][MAG_W-1:0]   mag;
    logic                    zero;
    quad_e                   quad;
    logic [TURN_W-1:0]       resid;
  } cls_t;

  // atan(2^-i) where 2^32 is one full turn.
  function automatic logic [TURN_W-1:0] atan_turn(input int unsigned idx);
    logic [TURN_W-1:0] val;
    case (idx)
      0:       val = 32'd536870912;
      1:       val = 32'd316933406;
      2:       val = 32'd167458907;
      3:       val = 32'd85004756;
      4:       val = 32'd42667331;
      5:       val = 32'd21354465;
      6:       val = 32'd10679838;
      7:       val = 32'd5340245;
      8:       val = 32'd2670163;
      9:       val = 32'd1335087;
      10:      val = 32'd667544;
      11:      val = 32'd333772;
      12:      val = 32'd166886;
      13:      val = 32'd83443;
      14:      val = 32'd41722;
      15:      val = 32'd20861;
      16:      val = 32'd10430;
      17:      val = 32'd5215;
      18:      val = 32'd2608;
      19:      val = 32'd1304;
      20:      val = 32'd652;
      21:      val = 32'd326;
      22:      val = 32'd163;
      23:      val = 32'd81;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== sv/rvaa_fifo.sv =====
// ----------------------------------------------------------------------------
// Rotation core queue
// Small register queue that decouples a producer from a consumer.
// ----------------------------------------------------------------------------
module rvaa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    cnt_q;
  logic             wr, rd;

  assign full_o    = (cnt_q == CW'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign wr        = wr_en_i && !full_o;
  assign rd        = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr && !rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd && !wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== sv/rvaa_front.sv =====
// ----------------------------------------------------------------------------
// Rotation core front end
// Detects a zero axis, prescales the axis magnitudes and splits the angle.
// ----------------------------------------------------------------------------
module rvaa_front
  import rvaa_pkg::*;
(
  input  in_item_t in_item_i,
  output cls_t     cls_o
);

  logic [2:0][COORD_W-1:0] axis;
  logic [2:0][COORD_W-1:0] mag;
  logic [COORD_W-1:0]      mx;
  logic [6:0]              len;
  logic [6:0]              shr, shl;
  logic [TURN_W-1:0]       turn, centered;
  logic [1:0]              quad;

  assign axis[0] = in_item_i.axis_x;
  assign axis[1] = in_item_i.axis_y;
  assign axis[2] = in_item_i.axis_z;

  // Magnitudes and the bit length of the largest one.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = axis[i][COORD_W-1] ? (~axis[i] + 1'b1) : axis[i];
    end
    mx  = mag[0] | mag[1] | mag[2];
    len = '0;
    for (int b = 0; b < COORD_W; b++) begin
      if (mx[b]) begin
        len = 7'(b + 1);
      end
    end
    shr = (len > 7'(MAG_W)) ? len - 7'(MAG_W) : '0;
    shl = (len > 7'(MAG_W)) ? '0 : 7'(MAG_W) - len;
  end

  // Angle widened to a full 32-bit turn, centered and split by quadrant.
  assign turn     = {in_item_i.turn_fraction, {(TURN_W-ANGLE_W){1'b0}}};
  assign centered = turn + {3'b001, {(TURN_W-3){1'b0}}};
  assign quad     = centered[TURN_W-1 -: 2];

  always_comb begin
    cls_o.point[0] = in_item_i.point_x;
    cls_o.point[1] = in_item_i.point_y;
    cls_o.point[2] = in_item_i.point_z;
    for (int i = 0; i < 3; i++) begin
      cls_o.neg[i] = axis[i][COORD_W-1];
      if (len > 7'(MAG_W)) begin
        cls_o.mag[i] = MAG_W'(mag[i] >> shr);
      end else begin
        cls_o.mag[i] = MAG_W'(mag[i] << shl);
      end
    end
    cls_o.zero  = (mx == '0);
    cls_o.quad  = quad_e'(quad);
    cls_o.resid = turn - {quad, {(TURN_W-2){1'b0}}};
  end

endmodule

// ===== sv/rvaa_back.sv =====
// ----------------------------------------------------------------------------
// Rotation core datapath
// Pipelined square root, axis divide, CORDIC, matrix build and multiply.
// ----------------------------------------------------------------------------
module rvaa_back
  import rvaa_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  cls_t      cls_i,
  output logic      pop_o,
  input  logic      out_full_i,
  output logic      out_wr_o,
  output out_item_t out_item_o
);

  localparam int SUM_W    = 64;
  localparam int RT_STEPS = 32;
  localparam int NORM_W   = 32;
  localparam int QUO_W    = MAG_W + 1;
  localparam int DV_STEPS = QUO_W;
  localparam int U_W      = QUO_W + 1;
  localparam int PR_W     = 34;
  localparam int UT_W     = 35;
  localparam int M_W      = 36;
  localparam int MP_W     = M_W + COORD_W;
  localparam int SUM3_W   = MP_W + 2;
  localparam int RND_W    = SUM3_W - UNIT_FRAC;
  localparam int NSTG     = 1 + (RT_STEPS + 1) + (DV_STEPS + 1) + 4 + 1;
  localparam longint HALF = 64'sd1 <<< (UNIT_FRAC - 1);
  localparam logic [CX_W-1:0] ONE_Q = CX_W'(64'sd1 <<< UNIT_FRAC);
  localparam logic signed [RND_W-1:0] CMAX =
    {{(RND_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [RND_W-1:0] CMIN =
    {{(RND_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    logic [2:0][COORD_W-1:0]   point;
    logic [2:0]                neg;
    logic [2:0][MAG_W-1:0]     mag;
    logic                      zero;
    quad_e                     quad;
    logic [TURN_W-1:0]         resid;
    logic [2:0][2*MAG_W-1:0]   sq;
  } sa_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] point;
    logic [2:0]              neg;
    logic [2:0][MAG_W-1:0]   mag;
    logic                    zero;
    quad_e                   quad;
    logic [SUM_W-1:0]        rem;
    logic [SUM_W-1:0]        root;
    logic [CX_W-1:0]         cx;
    logic [CX_W-1:0]         cy;
    logic [CX_W-1:0]         cz;
  } rt_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] point;
    logic [2:0]              neg;
    logic [2:0]              lsb;
    logic                    zero;
    logic [CX_W-1:0]         cosv;
    logic [CX_W-1:0]         sinv;
    logic [NORM_W-1:0]       norm;
    logic [2:0][NORM_W-1:0]  rem;
    logic [2:0][QUO_W-1:0]   quo;
  } dv_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] point;
    logic                    zero;
    logic [CX_W-1:0]         cosv;
    logic [PR_W-1:0]         omc;
    logic [8:0][PR_W-1:0]    uu;
    logic [2:0][PR_W-1:0]    us;
  } m1_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] point;
    logic                    zero;
    logic [CX_W-1:0]         cosv;
    logic [2:0][PR_W-1:0]    us;
    logic [8:0][UT_W-1:0]    ut;
  } m2_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] point;
    logic                    zero;
    logic [8:0][M_W-1:0]     mat;
  } m3_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] point;
    logic                    zero;
    logic [8:0][MP_W-1:0]    prod;
  } m4_t;

  logic [NSTG-1:0] vld_q;
  logic            en, take;

  sa_t       sa_q, sa_d;
  rt_t       rt_q [RT_STEPS+1];
  rt_t       rt_d [RT_STEPS+1];
  dv_t       dv_q [DV_STEPS+1];
  dv_t       dv_d [DV_STEPS+1];
  m1_t       m1_q, m1_d;
  m2_t       m2_q, m2_d;
  m3_t       m3_q, m3_d;
  m4_t       m4_q, m4_d;
  out_item_t out_q, out_d;

  // The whole pipeline moves unless the result queue is full with a result waiting.
  assign en       = !out_full_i || !vld_q[NSTG-1];
  assign take     = en && in_valid_i;
  assign pop_o    = take;
  assign out_wr_o = en && vld_q[NSTG-1];
  assign out_item_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  // Squares of the prescaled axis magnitudes.
  always_comb begin
    sa_d.point = cls_i.point;
    sa_d.neg   = cls_i.neg;
    sa_d.mag   = cls_i.mag;
    sa_d.zero  = cls_i.zero;
    sa_d.quad  = cls_i.quad;
    sa_d.resid = cls_i.resid;
    for (int i = 0; i < 3; i++) begin
      sa_d.sq[i] = cls_i.mag[i] * cls_i.mag[i];
    end
  end

  // Square root one result bit per stage; the CORDIC runs alongside.
  always_comb begin
    logic [SUM_W-1:0] rbit, trial;
    logic [CX_W-1:0]  xs, ys, at;
    rbit  = '0;
    trial = '0;
    xs    = '0;
    ys    = '0;
    at    = '0;
    rt_d[0].point = sa_q.point;
    rt_d[0].neg   = sa_q.neg;
    rt_d[0].mag   = sa_q.mag;
    rt_d[0].zero  = sa_q.zero;
    rt_d[0].quad  = sa_q.quad;
    rt_d[0].rem   = SUM_W'(sa_q.sq[0]) + SUM_W'(sa_q.sq[1]) + SUM_W'(sa_q.sq[2]);
    rt_d[0].root  = '0;
    rt_d[0].cx    = CORDIC_GAIN;
    rt_d[0].cy    = '0;
    rt_d[0].cz    = CX_W'($signed(sa_q.resid));
    for (int k = 0; k < RT_STEPS; k++) begin
      rt_d[k+1] = rt_q[k];
      rbit  = SUM_W'(1) << (2 * (RT_STEPS - 1 - k));
      trial = rt_q[k].root + rbit;
      if (rt_q[k].rem >= trial) begin
        rt_d[k+1].rem  = rt_q[k].rem - trial;
        rt_d[k+1].root = (rt_q[k].root >> 1) + rbit;
      end else begin
        rt_d[k+1].root = rt_q[k].root >> 1;
      end
      if (k < CORDIC_STEPS && k < ATAN_ENTRIES) begin
        xs = CX_W'($signed(rt_q[k].cx) >>> k);
        ys = CX_W'($signed(rt_q[k].cy) >>> k);
        at = CX_W'(atan_turn(k));
        if (!rt_q[k].cz[CX_W-1]) begin
          rt_d[k+1].cx = rt_q[k].cx - ys;
          rt_d[k+1].cy = rt_q[k].cy + xs;
          rt_d[k+1].cz = rt_q[k].cz - at;
        end else begin
          rt_d[k+1].cx = rt_q[k].cx + ys;
          rt_d[k+1].cy = rt_q[k].cy - xs;
          rt_d[k+1].cz = rt_q[k].cz + at;
        end
      end
    end
  end

  // Restoring divide of each magnitude by the norm, one quotient bit per stage.
  always_comb begin
    logic [NORM_W:0] r2;
    logic            bin;
    r2  = '0;
    bin = 1'b0;
    dv_d[0].point = rt_q[RT_STEPS].point;
    dv_d[0].neg   = rt_q[RT_STEPS].neg;
    dv_d[0].zero  = rt_q[RT_STEPS].zero;
    dv_d[0].norm  = (rt_q[RT_STEPS].root == '0) ? NORM_W'(1)
                                                : NORM_W'(rt_q[RT_STEPS].root);
    for (int i = 0; i < 3; i++) begin
      dv_d[0].lsb[i] = rt_q[RT_STEPS].mag[i][0];
      dv_d[0].rem[i] = NORM_W'(rt_q[RT_STEPS].mag[i] >> 1);
      dv_d[0].quo[i] = '0;
    end
    unique case (rt_q[RT_STEPS].quad)
      QUAD_0: begin
        dv_d[0].cosv = rt_q[RT_STEPS].cx;
        dv_d[0].sinv = rt_q[RT_STEPS].cy;
      end
      QUAD_1: begin
        dv_d[0].cosv = -rt_q[RT_STEPS].cy;
        dv_d[0].sinv = rt_q[RT_STEPS].cx;
      end
      QUAD_2: begin
        dv_d[0].cosv = -rt_q[RT_STEPS].cx;
        dv_d[0].sinv = -rt_q[RT_STEPS].cy;
      end
      QUAD_3: begin
        dv_d[0].cosv = rt_q[RT_STEPS].cy;
        dv_d[0].sinv = -rt_q[RT_STEPS].cx;
      end
      default: begin
        dv_d[0].cosv = rt_q[RT_STEPS].cx;
        dv_d[0].sinv = rt_q[RT_STEPS].cy;
      end
    endcase
    for (int l = 0; l < DV_STEPS; l++) begin
      dv_d[l+1] = dv_q[l];
      for (int i = 0; i < 3; i++) begin
        bin = (l == 0) ? dv_q[l].lsb[i] : 1'b0;
        r2  = {dv_q[l].rem[i], bin};
        if (r2 >= {1'b0, dv_q[l].norm}) begin
          dv_d[l+1].rem[i] = NORM_W'(r2 - {1'b0, dv_q[l].norm});
          dv_d[l+1].quo[i] = {dv_q[l].quo[i][QUO_W-2:0], 1'b1};
        end else begin
          dv_d[l+1].rem[i] = NORM_W'(r2);
          dv_d[l+1].quo[i] = {dv_q[l].quo[i][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  // Unit axis products u*u^T and u*sin, each rounded to Q4.30.
  always_comb begin
    logic signed [U_W-1:0]        u [3];
    logic signed [2*U_W-1:0]      p_uu;
    logic signed [U_W+CX_W-1:0]   p_us;
    for (int i = 0; i < 3; i++) begin
      u[i] = dv_q[DV_STEPS].neg[i] ? -$signed({1'b0, dv_q[DV_STEPS].quo[i]})
                                   : $signed({1'b0, dv_q[DV_STEPS].quo[i]});
    end
    p_uu = '0;
    p_us = '0;
    m1_d.point = dv_q[DV_STEPS].point;
    m1_d.zero  = dv_q[DV_STEPS].zero;
    m1_d.cosv  = dv_q[DV_STEPS].cosv;
    m1_d.omc   = PR_W'(ONE_Q - dv_q[DV_STEPS].cosv);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p_uu = u[i] * u[j];
        m1_d.uu[3*i+j] = PR_W'((p_uu + (2*U_W)'(HALF)) >>> UNIT_FRAC);
      end
      p_us = u[i] * $signed(dv_q[DV_STEPS].sinv);
      m1_d.us[i] = PR_W'((p_us + (U_W+CX_W)'(HALF)) >>> UNIT_FRAC);
    end
  end

  // Scale the outer product by one minus cosine.
  always_comb begin
    logic signed [2*PR_W-1:0] p_ut;
    p_ut = '0;
    m2_d.point = m1_q.point;
    m2_d.zero  = m1_q.zero;
    m2_d.cosv  = m1_q.cosv;
    m2_d.us    = m1_q.us;
    for (int e = 0; e < 9; e++) begin
      p_ut = $signed(m1_q.uu[e]) * $signed(m1_q.omc);
      m2_d.ut[e] = UT_W'((p_ut + (2*PR_W)'(HALF)) >>> UNIT_FRAC);
    end
  end

  // Add cosine on the diagonal and the cross-product terms off it.
  always_comb begin
    logic signed [M_W-1:0] c_e, s0, s1, s2;
    c_e = M_W'($signed(m2_q.cosv));
    s0  = M_W'($signed(m2_q.us[0]));
    s1  = M_W'($signed(m2_q.us[1]));
    s2  = M_W'($signed(m2_q.us[2]));
    m3_d.point = m2_q.point;
    m3_d.zero  = m2_q.zero;
    for (int e = 0; e < 9; e++) begin
      m3_d.mat[e] = M_W'($signed(m2_q.ut[e]));
    end
    m3_d.mat[0] = m3_d.mat[0] + c_e;
    m3_d.mat[4] = m3_d.mat[4] + c_e;
    m3_d.mat[8] = m3_d.mat[8] + c_e;
    m3_d.mat[1] = m3_d.mat[1] - s2;
    m3_d.mat[3] = m3_d.mat[3] + s2;
    m3_d.mat[2] = m3_d.mat[2] + s1;
    m3_d.mat[6] = m3_d.mat[6] - s1;
    m3_d.mat[5] = m3_d.mat[5] - s0;
    m3_d.mat[7] = m3_d.mat[7] + s0;
  end

  // Matrix times point, one product per entry.
  always_comb begin
    m4_d.point = m3_q.point;
    m4_d.zero  = m3_q.zero;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m4_d.prod[3*i+j] = MP_W'($signed(m3_q.mat[3*i+j]) * $signed(m3_q.point[j]));
      end
    end
  end

  // Row sums, rounding and saturation; a zero axis passes the point through.
  always_comb begin
    logic signed [SUM3_W-1:0] acc;
    logic signed [RND_W-1:0]  rnd;
    logic [2:0][COORD_W-1:0]  res;
    logic [2:0]               clip;
    acc = '0;
    rnd = '0;
    for (int i = 0; i < 3; i++) begin
      acc = $signed(m4_q.prod[3*i]) + $signed(m4_q.prod[3*i+1])
          + $signed(m4_q.prod[3*i+2]);
      rnd = RND_W'((acc + SUM3_W'(HALF)) >>> UNIT_FRAC);
      if (rnd > CMAX) begin
        res[i]  = CMAX[COORD_W-1:0];
        clip[i] = 1'b1;
      end else if (rnd < CMIN) begin
        res[i]  = CMIN[COORD_W-1:0];
        clip[i] = 1'b1;
      end else begin
        res[i]  = rnd[COORD_W-1:0];
        clip[i] = 1'b0;
      end
    end
    if (m4_q.zero) begin
      out_d.rotated_x = m4_q.point[0];
      out_d.rotated_y = m4_q.point[1];
      out_d.rotated_z = m4_q.point[2];
      out_d.zero_axis = 1'b1;
      out_d.saturated = 1'b0;
    end else begin
      out_d.rotated_x = res[0];
      out_d.rotated_y = res[1];
      out_d.rotated_z = res[2];
      out_d.zero_axis = 1'b0;
      out_d.saturated = |clip;
    end
  end

  // Pipeline payload registers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q  <= sa_d;
      rt_q  <= rt_d;
      dv_q  <= dv_d;
      m1_q  <= m1_d;
      m2_q  <= m2_d;
      m3_q  <= m3_d;
      m4_q  <= m4_d;
      out_q <= out_d;
    end
  end

endmodule

// ===== sv/rotate_vector_about_axis_core.sv =====
// ----------------------------------------------------------------------------
// Axis-angle point rotation core
// Rotates a Q16.16 point about an arbitrary axis by a fraction of a turn.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the in channel (in_valid_i, in_stall_o, in_item_i) and
//   results leave on the out channel (out_valid_o, out_stall_i, out_item_o).
//   A transfer happens on a rising edge with valid high and stall low.
//   Each item gives exactly one result, in order.
// Pipelining:
//   The datapath is fully pipelined: one item per cycle is sustained while
//   the receiver does not stall. The datapath holds a 32-stage square root
//   and a 31-stage divide, each resolving one bit per stage; the CORDIC
//   runs beside the root.
// Stalls:
//   A four-entry queue sits between the front end and the datapath, and a
//   two-entry result queue at the output. When the receiver stalls, the
//   datapath freezes once a result waits on a full output queue; input
//   stall rises when the front queue fills.
// Reset:
//   Reset is asynchronous and empties both queues and the pipeline.
// ----------------------------------------------------------------------------
module rotate_vector_about_axis_core
  import rvaa_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  cls_t                        cls_in, cls_head;
  logic [$bits(cls_t)-1:0]     q_rd_data;
  logic                        q_full, q_empty, q_pop;
  logic [$bits(out_item_t)-1:0] o_rd_data;
  out_item_t                   res_item;
  logic                        o_full, o_empty, res_wr;

  // Front end: classify each item on the way into the queue.
  rvaa_front u_front (
    .in_item_i (in_item_i),
    .cls_o     (cls_in)
  );

  rvaa_fifo #(
    .WIDTH ($bits(cls_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_valid_i),
    .wr_data_i (cls_in),
    .rd_en_i   (q_pop),
    .rd_data_o (q_rd_data),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  assign in_stall_o = q_full;
  assign cls_head   = cls_t'(q_rd_data);

  // Back end: the arithmetic pipeline.
  rvaa_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (!q_empty),
    .cls_i      (cls_head),
    .pop_o      (q_pop),
    .out_full_i (o_full),
    .out_wr_o   (res_wr),
    .out_item_o (res_item)
  );

  // Result queue in front of the output channel.
  rvaa_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_wr),
    .wr_data_i (res_item),
    .rd_en_i   (!out_stall_i),
    .rd_data_o (o_rd_data),
    .full_o    (o_full),
    .empty_o   (o_empty)
  );

  assign out_valid_o = !o_empty;
  assign out_item_o  = out_item_t'(o_rd_data);

endmodule

// ===== sv/rvaa_checker.sv =====
// ----------------------------------------------------------------------------
// Rotation core port checker
// Checks the channel behavior seen on the top-level ports over time.
// ----------------------------------------------------------------------------
module rvaa_checker
  import rvaa_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // A stalled result holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
  else $error("stalled result changed");

  // A stalled input transfer holds its payload until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
  else $error("stalled input changed");

  // A pass-through result never reports clamping.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.zero_axis && out_item_o.saturated))
  else $error("zero axis result flagged as saturated");

  // No result is offered in the cycle after reset was seen.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
  else $error("result offered during reset");

  // The input side is open right after reset.
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !in_stall_o)
  else $error("input stalled after reset");

endmodule

bind rotate_vector_about_axis_core rvaa_checker u_rvaa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
